// File: design/murmur2_string_hash_bucket_macros.svh
// Assertion macros used by the hash bucket mixing engine.
`ifndef MURMUR2_STRING_HASH_BUCKET_MACROS_SVH
`define MURMUR2_STRING_HASH_BUCKET_MACROS_SVH

// Plain clocked assertion, disabled while reset is asserted.
`define MMH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in this cycle implies a property in the next one.
`define MMH_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  `MMH_ASSERT(label, clk, rst_n, (cond) |=> (prop), msg)

`endif

// File: design/mmh_pkg.sv
// Package with constants and command type for the MurmurHash2 bucket hasher.
`timescale 1ns / 1ps
`default_nettype none

package mmh_pkg;

  // Hash constants
  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  // Configuration register indexes and reset values
  localparam logic        CFG_BUCKET_COUNT = 1'b0;
  localparam logic        CFG_HASH_SEED    = 1'b1;
  localparam logic [31:0] BUCKET_COUNT_RST = 32'd1024;
  localparam logic [31:0] HASH_SEED_RST    = 32'd97;

  // Work handed from the byte packer to the mixing engine
  typedef struct packed {
    logic        init_en;   // load the running hash with init_val
    logic [31:0] init_val;  // seed ^ key length
    logic        mix_en;    // data holds a full word to mix
    logic        fin_en;    // finish the key and emit a result
    logic        tail_en;   // data[23:0] holds 1 to 3 tail bytes
    logic [31:0] data;
  } mmh_cmd_t;

endpackage

`default_nettype wire

// File: design/mmh_if.sv
// Valid/ready channel interfaces for key bytes and hash results.
`timescale 1ns / 1ps
`default_nettype none

interface mmh_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [15:0] key_length;

  modport source (output valid, data_byte, first_byte, last_byte, key_length, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, key_length, output ready);
endinterface

interface mmh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic [31:0] bucket_index;

  modport source (output valid, hash_value, bucket_index, input ready);
  modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface

`default_nettype wire

// File: design/mmh_queue.sv
// Small command FIFO between the byte packer and the mixing engine.
`timescale 1ns / 1ps
`default_nettype none

module mmh_queue
  import mmh_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire mmh_cmd_t  push_cmd,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output mmh_cmd_t       pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mmh_cmd_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/mmh_front.sv
// Byte packer: gathers key bytes into words and issues mix/finish commands.
`timescale 1ns / 1ps
`default_nettype none

module mmh_front
  import mmh_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  mmh_in_if.sink      in_ch,
  input  wire logic [31:0] hash_seed,
  output logic        push_valid,
  input  wire logic   push_ready,
  output mmh_cmd_t    push_cmd
);

  logic [23:0] partial_r;
  logic [1:0]  held_r;
  logic [23:0] partial_nxt;
  logic [1:0]  held_nxt;

  logic [23:0] p_base;
  logic [1:0]  h_base;
  logic [23:0] p_abs;
  logic [1:0]  h_abs;
  logic        absorb;
  logic        mix;
  logic        accept;

  // Pack the byte; a first byte restarts from an empty word
  always_comb begin
    p_base = in_ch.first_byte ? '0 : partial_r;
    h_base = in_ch.first_byte ? '0 : held_r;
    absorb = !(in_ch.first_byte && (in_ch.key_length == '0));
    mix    = absorb && (h_base == 2'd3);
    p_abs  = p_base;
    h_abs  = h_base;
    if (absorb) begin
      case (h_base)
        2'd0:    p_abs = {p_base[23:8], in_ch.data_byte};
        2'd1:    p_abs = {p_base[23:16], in_ch.data_byte, p_base[7:0]};
        2'd2:    p_abs = {in_ch.data_byte, p_base[15:0]};
        default: p_abs = '0;
      endcase
      h_abs = h_base + 2'd1;
    end
  end

  // Command to the mixing engine
  always_comb begin
    push_cmd.init_en  = in_ch.first_byte;
    push_cmd.init_val = hash_seed ^ {16'b0, in_ch.key_length};
    push_cmd.mix_en   = mix;
    push_cmd.fin_en   = in_ch.last_byte;
    push_cmd.tail_en  = (h_abs != 2'd0);
    push_cmd.data     = mix ? {in_ch.data_byte, p_base} : {8'b0, p_abs};
  end

  assign push_valid  = in_ch.valid && (in_ch.first_byte || mix || in_ch.last_byte);
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // A finished key leaves nothing behind
  always_comb begin
    partial_nxt = partial_r;
    held_nxt    = held_r;
    if (accept) begin
      partial_nxt = in_ch.last_byte ? '0 : p_abs;
      held_nxt    = in_ch.last_byte ? '0 : h_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      held_r    <= '0;
    end else begin
      partial_r <= partial_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/mmh_back.sv
// Mixing engine: word mixes, final mixes and bucket remainder, with result register.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur2_string_hash_bucket_macros.svh"

module mmh_back
  import mmh_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  input  wire mmh_cmd_t pop_cmd,
  input  wire logic [31:0] bucket_count,
  mmh_out_if.source   out_ch
);

  localparam int DIV_STEPS = 32;
  localparam int SW = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_K1, S_K2, S_H1, S_T1, S_F1, S_F2, S_DIV, S_EMIT
  } state_t;

  state_t        state_r;
  logic          fin_r;
  logic          tail_en_r;
  logic [31:0]   data_r;
  logic [31:0]   k_r;
  logic [31:0]   h_r;
  logic [31:0]   hash_r;
  logic [31:0]   div_r;
  logic [31:0]   rem_r;
  logic [31:0]   dvd_r;
  logic [SW-1:0] cnt_r;
  logic          out_valid_r;
  logic [31:0]   out_hash_r;
  logic [31:0]   out_bucket_r;

  logic [31:0]   mul_a;
  logic [31:0]   mul_p;
  logic [32:0]   trial;
  logic [31:0]   rem_nxt;
  logic          out_free;

  // Shared multiplier by the mix constant; operand chosen by step
  always_comb begin
    case (state_r)
      S_K1:    mul_a = data_r;
      S_K2:    mul_a = k_r ^ (k_r >> MIX_SHIFT);
      S_H1:    mul_a = h_r;
      S_T1:    mul_a = h_r ^ {8'b0, data_r[23:0]};
      S_F1:    mul_a = h_r ^ (h_r >> FIN_SHIFT_A);
      default: mul_a = data_r;
    endcase
  end
  assign mul_p = mul_a * MIX_MUL;

  // One restoring remainder step; a zero divisor leaves the dividend
  assign trial   = {rem_r, dvd_r[31]};
  assign rem_nxt = (trial >= {1'b0, div_r}) ? 32'(trial - {1'b0, div_r}) : trial[31:0];

  assign pop_ready    = (state_r == S_IDLE);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.hash_value   = out_hash_r;
  assign out_ch.bucket_index = out_bucket_r;

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            fin_r     <= pop_cmd.fin_en;
            tail_en_r <= pop_cmd.tail_en;
            data_r    <= pop_cmd.data;
            if (pop_cmd.init_en) begin
              h_r <= pop_cmd.init_val;
            end
            if (pop_cmd.mix_en) begin
              state_r <= S_K1;
            end else if (pop_cmd.fin_en) begin
              state_r <= pop_cmd.tail_en ? S_T1 : S_F1;
            end
          end
        end
        S_K1: begin
          k_r     <= mul_p;
          state_r <= S_K2;
        end
        S_K2: begin
          k_r     <= mul_p;
          state_r <= S_H1;
        end
        S_H1: begin
          h_r <= mul_p ^ k_r;
          if (fin_r) begin
            state_r <= tail_en_r ? S_T1 : S_F1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_T1: begin
          h_r     <= mul_p;
          state_r <= S_F1;
        end
        S_F1: begin
          h_r     <= mul_p;
          state_r <= S_F2;
        end
        S_F2: begin
          hash_r  <= h_r ^ (h_r >> FIN_SHIFT_B);
          dvd_r   <= h_r ^ (h_r >> FIN_SHIFT_B);
          div_r   <= bucket_count;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[30:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == SW'(DIV_STEPS - 1)) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_hash_r   <= hash_r;
            out_bucket_r <= rem_r;
            out_valid_r  <= 1'b1;
            h_r          <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Remainder stays below a nonzero divisor throughout the division
  `MMH_ASSERT(a_rem_bound, clk, rst_n, (state_r == S_DIV && div_r != '0) |-> (rem_r < div_r), "remainder out of range")
  // Division always starts from a cleared remainder
  `MMH_ASSERT_NEXT(a_div_start, clk, rst_n, state_r == S_F2, state_r == S_DIV && rem_r == '0, "division start")
  // A result leaves the engine idle with a cleared running hash
  `MMH_ASSERT_NEXT(a_emit, clk, rst_n, state_r == S_EMIT && out_free, out_valid_r && state_r == S_IDLE && h_r == '0, "emit")

endmodule

`default_nettype wire

// File: design/murmur2_string_hash_bucket.sv
// Top level of the MurmurHash2 string hasher with bucket index.
`timescale 1ns / 1ps
`default_nettype none

// Key bytes enter one per transfer on in_ch; first_byte starts a key and carries its length,
// last_byte ends it and yields one transfer on out_ch with the 32-bit MurmurHash2 and that hash
// modulo bucket_count (a zero count returns the hash). The packer takes a byte every cycle while
// the command queue has room. The engine behind it has one multiplier: each full word is taken
// from the queue and then passes three multiplies there, so bytes stream at one per cycle on
// average between key ends. Key end holds the engine after the last word mix, or from taking the
// end command when no word closes on the last byte: taking that command when it carries no word,
// one or two tail and final multiplies, the last xor-shift, a bit-serial remainder and loading
// the result register once out_ch can take it. The next key's bytes are accepted meanwhile until
// the queue of QUEUE_DEPTH commands fills. The seed and bucket count are to be written on the
// cfg port between keys only; the block itself does not enforce this.
module murmur2_string_hash_bucket
  import mmh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mmh_in_if.sink           in_ch,
  mmh_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [31:0] bucket_count_r;
  logic [31:0] hash_seed_r;

  logic        push_valid;
  logic        push_ready;
  mmh_cmd_t    push_cmd;
  logic        pop_valid;
  logic        pop_ready;
  mmh_cmd_t    pop_cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RST;
      hash_seed_r    <= HASH_SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
        CFG_HASH_SEED:    hash_seed_r    <= cfg_wdata;
      endcase
    end
  end

  mmh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .hash_seed  (hash_seed_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  mmh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  mmh_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .bucket_count (bucket_count_r),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire
